/* sv/efte_pkg.sv */
// ----------------------------------------------------------------------------
// efte_pkg
// shared types and constants of the eventually-follows transition extractor
// ----------------------------------------------------------------------------
package efte_pkg;

    localparam int NUM_EVENT_TYPES = 32;
    localparam int EVENT_ID_W      = 5;
    localparam int TIME_W          = 31;
    localparam int ELAPSED_W       = 32;

    typedef struct packed {
        logic [EVENT_ID_W-1:0] event_id;
        logic [TIME_W-1:0]     event_time;
        logic                  end_of_sequence;
    } t_in;

    typedef struct packed {
        logic [EVENT_ID_W-1:0]       from_event;
        logic [EVENT_ID_W-1:0]       to_event;
        logic signed [ELAPSED_W-1:0] elapsed;
        logic                        last_of_run;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_OPEN,
        S_FLUSH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic step;
        logic emit;
        logic wr_seen;
        logic open_slot;
        logic flush;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic ev_valid;
        logic slot_open;
        logic slot_last;
        logic hit;
        logic pend_vld;
        logic out_free;
    } t_sts;

endpackage

/* sv/efte_ram.sv */
// ----------------------------------------------------------------------------
// efte_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module efte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/efte_ctrl.sv */
// ----------------------------------------------------------------------------
// efte_ctrl
// slot scan sequencer: walks the slots, orders reads, results and reopening
// ----------------------------------------------------------------------------
module efte_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  efte_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output efte_pkg::t_cmd  o_cmd
);

    efte_pkg::t_state r_state;
    efte_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= efte_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            efte_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = efte_pkg::S_SCAN;
                end
            end
            efte_pkg::S_SCAN: begin
                if (!i_sts.ev_valid) begin
                    n_state = efte_pkg::S_OPEN;
                end else if (i_sts.slot_open) begin
                    n_state = efte_pkg::S_CHECK;
                end else if (i_sts.slot_last) begin
                    n_state = efte_pkg::S_OPEN;
                end
            end
            efte_pkg::S_CHECK: begin
                if (!(i_sts.hit && i_sts.pend_vld && !i_sts.out_free)) begin
                    n_state = i_sts.slot_last ? efte_pkg::S_OPEN : efte_pkg::S_SCAN;
                end
            end
            efte_pkg::S_OPEN: begin
                n_state = efte_pkg::S_FLUSH;
            end
            efte_pkg::S_FLUSH: begin
                if (!i_sts.pend_vld || i_sts.out_free) begin
                    n_state = efte_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = efte_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            efte_pkg::S_IDLE: begin
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            efte_pkg::S_SCAN: begin
                if (i_sts.ev_valid) begin
                    o_cmd.rd   = i_sts.slot_open;
                    o_cmd.step = !i_sts.slot_open && !i_sts.slot_last;
                end
            end
            efte_pkg::S_CHECK: begin
                if (!(i_sts.hit && i_sts.pend_vld && !i_sts.out_free)) begin
                    o_cmd.emit    = i_sts.hit;
                    o_cmd.wr_seen = i_sts.hit;
                    o_cmd.step    = !i_sts.slot_last;
                end
            end
            efte_pkg::S_OPEN: begin
                o_cmd.open_slot = 1'b1;
            end
            efte_pkg::S_FLUSH: begin
                o_cmd.flush = i_sts.pend_vld && i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* sv/efte_dp.sv */
// ----------------------------------------------------------------------------
// efte_dp
// datapath: event register, slot counter, open bits, slot ram, result queue
// ----------------------------------------------------------------------------
module efte_dp #(
    parameter int NUM_EVENT_TYPES = efte_pkg::NUM_EVENT_TYPES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  efte_pkg::t_in   i_in_data,
    input  efte_pkg::t_cmd  i_cmd,
    input  logic            i_out_ready,
    output efte_pkg::t_sts  o_sts,
    output logic            o_out_valid,
    output efte_pkg::t_out  o_out_data
);

    localparam int IW  = $clog2(NUM_EVENT_TYPES);
    localparam int CW  = (IW > efte_pkg::EVENT_ID_W) ? IW : efte_pkg::EVENT_ID_W;
    localparam int CW1 = CW + 1;
    localparam int RW  = efte_pkg::TIME_W + NUM_EVENT_TYPES;

    logic [efte_pkg::EVENT_ID_W-1:0] r_ev_id;
    logic [efte_pkg::TIME_W-1:0]     r_time;
    logic                            r_eos;
    logic [IW-1:0]                   r_slot;
    logic [IW-1:0]                   n_slot;
    logic [NUM_EVENT_TYPES-1:0]      r_open;
    logic [NUM_EVENT_TYPES-1:0]      n_open;
    logic                            r_pend_vld;
    logic                            n_pend_vld;
    efte_pkg::t_out                  r_pend;
    efte_pkg::t_out                  n_pend;
    logic                            r_out_vld;
    logic                            n_out_vld;
    efte_pkg::t_out                  r_out;
    efte_pkg::t_out                  n_out;

    logic                            ev_valid;
    logic [IW-1:0]                   ev_idx;
    logic [NUM_EVENT_TYPES-1:0]      ev_bit;
    logic [CW-1:0]                   slot_ext;
    logic                            is_self;
    logic                            out_free;
    logic [RW-1:0]                   rd_data;
    logic [NUM_EVENT_TYPES-1:0]      rd_seen;
    logic [efte_pkg::TIME_W-1:0]     rd_time;
    logic                            hit;
    efte_pkg::t_out                  res;
    logic                            ram_we;
    logic [IW-1:0]                   ram_waddr;
    logic [RW-1:0]                   ram_wdata;

    assign ev_valid = ({{(CW1 - efte_pkg::EVENT_ID_W){1'b0}}, r_ev_id} < CW1'(NUM_EVENT_TYPES));
    assign ev_idx   = IW'(r_ev_id);
    assign ev_bit   = {{(NUM_EVENT_TYPES - 1){1'b0}}, 1'b1} << ev_idx;
    assign slot_ext = CW'(r_slot);
    assign is_self  = (slot_ext == CW'(r_ev_id));
    assign out_free = !r_out_vld || i_out_ready;
    assign rd_seen  = rd_data[RW-1:efte_pkg::TIME_W];
    assign rd_time  = rd_data[efte_pkg::TIME_W-1:0];
    assign hit      = is_self || !rd_seen[ev_idx];

    always_comb begin
        res.from_event  = slot_ext[efte_pkg::EVENT_ID_W-1:0];
        res.to_event    = r_ev_id;
        res.elapsed     = {1'b0, r_time} - {1'b0, rd_time};
        res.last_of_run = 1'b0;
    end

    // slot ram write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = {rd_seen | ev_bit, rd_time};
        if (i_cmd.wr_seen) begin
            ram_we = 1'b1;
        end else if (i_cmd.open_slot) begin
            ram_we    = ev_valid;
            ram_waddr = ev_idx;
            ram_wdata = {{NUM_EVENT_TYPES{1'b0}}, r_time};
        end
    end

    efte_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_EVENT_TYPES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_slot),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_slot     = r_slot;
        n_open     = r_open;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if (i_cmd.load) begin
            n_slot = '0;
        end else if (i_cmd.step) begin
            n_slot = r_slot + IW'(1);
        end
        if (i_cmd.emit) begin
            if (r_pend_vld) begin
                n_out_vld = 1'b1;
                n_out     = r_pend;
            end
            n_pend_vld = 1'b1;
            n_pend     = res;
        end
        if (i_cmd.flush) begin
            n_out_vld             = 1'b1;
            n_out                 = r_pend;
            n_out.last_of_run     = 1'b1;
            n_pend_vld            = 1'b0;
        end
        if (i_cmd.open_slot) begin
            if (ev_valid) begin
                n_open = r_open | ev_bit;
            end
            if (r_eos) begin
                n_open = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_open     <= n_open;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_pend <= n_pend;
        r_out  <= n_out;
        if (i_cmd.load) begin
            r_ev_id <= i_in_data.event_id;
            r_time  <= i_in_data.event_time;
            r_eos   <= i_in_data.end_of_sequence;
        end
    end

    always_comb begin
        o_sts.ev_valid  = ev_valid;
        o_sts.slot_open = r_open[r_slot];
        o_sts.slot_last = (r_slot == IW'(NUM_EVENT_TYPES - 1));
        o_sts.hit       = hit;
        o_sts.pend_vld  = r_pend_vld;
        o_sts.out_free  = out_free;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_load_pend_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !r_pend_vld)
        else $error("item taken while a result is still pending");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_pend_vld) || i_cmd.flush |-> out_free)
        else $error("result pushed into a busy output register");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_seen |-> !i_cmd.open_slot)
        else $error("two slot ram writes in one cycle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_out_ready |=> r_out_vld && $stable(r_out))
        else $error("waiting result overwritten");

endmodule

/* sv/eventually_follows_transition_extractor_top.sv */
// ----------------------------------------------------------------------------
// eventually_follows_transition_extractor_top
// reports first later occurrences of each event type against open slots
// ----------------------------------------------------------------------------
//  channel  signals                              payload
//  in       i_in_valid  / o_in_ready             efte_pkg::t_in
//  out      o_out_valid / i_out_ready            efte_pkg::t_out
//
//  one item at a time: the slot scan passes each closed slot and reads the
//  ram and checks each open slot, then the item opens its slot and the last
//  result is flushed; a full output register stalls the check and the flush
//  an item of an out-of-range type skips the scan
//  the last result of an item may still wait while the next item is taken
//  reset (synchronous, active low) closes all slots and empties the outputs
// ----------------------------------------------------------------------------
module eventually_follows_transition_extractor_top #(
    parameter int NUM_EVENT_TYPES = efte_pkg::NUM_EVENT_TYPES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  efte_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output efte_pkg::t_out o_out_data
);

    efte_pkg::t_cmd cmd;
    efte_pkg::t_sts sts;

    efte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    efte_dp #(
        .NUM_EVENT_TYPES (NUM_EVENT_TYPES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* test/efte_transition_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efte_transition_checker
// watches both channels of the transition extractor, keeps its own copy of
// the slot state, predicts the transitions of every accepted event and
// compares each accepted result with the oldest one still due
// ----------------------------------------------------------------------------
module efte_transition_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  efte_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  efte_pkg::t_out i_out_data,
    output int             o_faults,
    output int             o_pending
);

    logic [efte_pkg::NUM_EVENT_TYPES-1:0] open_slots;
    logic [efte_pkg::TIME_W-1:0]          base_time  [efte_pkg::NUM_EVENT_TYPES];
    logic [efte_pkg::NUM_EVENT_TYPES-1:0] seen_types [efte_pkg::NUM_EVENT_TYPES];
    efte_pkg::t_out                       transitions_due [$];
    int                                   fault_count = 0;

    assign o_faults  = fault_count;
    assign o_pending = transitions_due.size();

    function automatic void predict_transitions(input efte_pkg::t_in ev);
        logic [efte_pkg::NUM_EVENT_TYPES-1:0] emit_mask;
        efte_pkg::t_out                       tr;
        emit_mask = '0;
        if (int'(ev.event_id) < efte_pkg::NUM_EVENT_TYPES) begin
            for (int s = 0; s < efte_pkg::NUM_EVENT_TYPES; s++) begin
                if (open_slots[s]) begin
                    if (s == int'(ev.event_id)) begin
                        emit_mask[s] = 1'b1;
                    end else if (!seen_types[s][ev.event_id]) begin
                        seen_types[s][ev.event_id] = 1'b1;
                        emit_mask[s] = 1'b1;
                    end
                end
            end
            for (int s = 0; s < efte_pkg::NUM_EVENT_TYPES; s++) begin
                if (emit_mask[s]) begin
                    tr.from_event  = s[efte_pkg::EVENT_ID_W-1:0];
                    tr.to_event    = ev.event_id;
                    tr.elapsed     = {1'b0, ev.event_time} - {1'b0, base_time[s]};
                    tr.last_of_run = ((emit_mask >> (s + 1)) == '0);
                    transitions_due = {transitions_due, tr};
                end
            end
            open_slots[ev.event_id] = 1'b1;
            base_time[ev.event_id]  = ev.event_time;
            seen_types[ev.event_id] = '0;
        end
        if (ev.end_of_sequence) begin
            open_slots = '0;
        end
    endfunction

    task automatic note_fault(input bit had_due, input efte_pkg::t_out due,
                              input efte_pkg::t_out got);
        fault_count++;
        if (fault_count <= 10) begin
            if (had_due) begin
                $display("%0t transition mismatch: expected from=%0d to=%0d",
                         $time, due.from_event, due.to_event);
                $display("    elapsed=%0d last=%0b,", due.elapsed, due.last_of_run);
                $display("    got from=%0d to=%0d elapsed=%0d last=%0b",
                         got.from_event, got.to_event, got.elapsed, got.last_of_run);
            end else begin
                $display("%0t unexpected transition from=%0d to=%0d elapsed=%0d last=%0b",
                         $time, got.from_event, got.to_event, got.elapsed,
                         got.last_of_run);
            end
        end
    endtask

    always @(posedge i_clk) begin
        efte_pkg::t_out due;
        if (!i_rst_n) begin
            open_slots = '0;
            transitions_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (transitions_due.size() == 0) begin
                    note_fault(1'b0, i_out_data, i_out_data);
                end else begin
                    due = transitions_due.pop_front();
                    if (i_out_data.from_event !== due.from_event ||
                        i_out_data.to_event !== due.to_event ||
                        i_out_data.elapsed !== due.elapsed ||
                        i_out_data.last_of_run !== due.last_of_run) begin
                        note_fault(1'b1, due, i_out_data);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_transitions(i_in_data);
            end
        end
    end

endmodule

/* test/eventually_follows_transition_extractor_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eventually_follows_transition_extractor_top_tb
// drives timed event sequences into the transition extractor under random
// idling on both channels and a long output hold-off, and gives the verdict
// from the failure and pending counts of the transition checker
// ----------------------------------------------------------------------------
module eventually_follows_transition_extractor_top_tb;

    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 150;
    localparam int PHASE_EVENTS  = 150;

    typedef logic [efte_pkg::TIME_W-1:0] t_stamp;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    efte_pkg::t_in  i_in_data;
    logic           o_out_valid;
    logic           i_out_ready;
    efte_pkg::t_out o_out_data;

    int fault_count;
    int transitions_pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;
    int quiet_cycles  = 0;

    eventually_follows_transition_extractor_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    efte_transition_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_faults    (fault_count),
        .o_pending   (transitions_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random ready, or a long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic efte_pkg::t_in event_item(input int id, input t_stamp stamp,
                                                 input bit last);
        efte_pkg::t_in ev;
        ev.event_id        = id[efte_pkg::EVENT_ID_W-1:0];
        ev.event_time      = stamp;
        ev.end_of_sequence = last;
        return ev;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer(input efte_pkg::t_in ev);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic directed_events();
        offer(event_item(0, '0, 1'b0));
        offer(event_item(31, '1, 1'b0));
        offer(event_item(0, '0, 1'b0));
        offer(event_item(31, t_stamp'(5), 1'b0));
        offer(event_item(5, t_stamp'(10), 1'b0));
        offer(event_item(5, t_stamp'(20), 1'b0));
        offer(event_item(31, t_stamp'(21), 1'b0));
        offer(event_item(7, t_stamp'(30), 1'b1));
        offer(event_item(9, t_stamp'(40), 1'b1));
        offer(event_item(9, t_stamp'(50), 1'b0));
        offer(event_item(9, '0, 1'b0));
        offer(event_item(20, '1, 1'b1));
    endtask

    task automatic random_events(input int count);
        int     sent;
        int     len;
        int     kind;
        int     span;
        int     lo;
        int     id;
        int     roll;
        bit     last;
        t_stamp stamp;
        sent  = 0;
        stamp = t_stamp'($urandom);
        while (sent < count) begin
            kind = $urandom_range(99);
            len  = (kind < 6) ? $urandom_range(32, 40) : $urandom_range(1, 20);
            span = $urandom_range(1, efte_pkg::NUM_EVENT_TYPES);
            lo   = $urandom_range(0, efte_pkg::NUM_EVENT_TYPES - span);
            for (int i = 0; i < len; i++) begin
                if (kind < 6) begin
                    id = (lo + i) % efte_pkg::NUM_EVENT_TYPES;
                end else if (kind < 90) begin
                    id = $urandom_range(lo, lo + span - 1);
                end else begin
                    id = $urandom_range(efte_pkg::NUM_EVENT_TYPES - 1);
                end
                roll = $urandom_range(99);
                if (roll < 80) begin
                    stamp = stamp + t_stamp'($urandom_range(0, 5000));
                end else if (roll < 90) begin
                    stamp = t_stamp'($urandom);
                end else if (roll < 95) begin
                    stamp = stamp - t_stamp'($urandom_range(1, 100));
                end else begin
                    stamp = $urandom_range(1) ? '1 : '0;
                end
                // part of the noise carries a random end marker, the last band is never closed
                if (kind >= 90 && kind < 95) begin
                    last = ($urandom_range(1) == 1);
                end else begin
                    last = (i == len - 1) && (kind < 95);
                end
                offer(event_item(id, stamp, last));
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_events();

        send_idle_pct = 7;
        recv_idle_pct = 79;
        random_events(PHASE_EVENTS);

        send_idle_pct = 79;
        recv_idle_pct = 7;
        random_events(PHASE_EVENTS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        random_events(PHASE_EVENTS);

        i_in_valid <= 1'b0;
        wait (transitions_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && transitions_pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
